// ===== design/rct_pkg.sv =====
// Package: constants, types and the divider step function for the color temperature pipeline.
package rct_pkg;

    localparam int unsigned CH_W            = 16;
    localparam int unsigned SET_W           = 8;
    localparam int unsigned SUM_W           = CH_W + 2;
    localparam int unsigned COEF_W          = 12;
    localparam int unsigned DIVIDEND_W      = CH_W + COEF_W;
    localparam int unsigned STEPS_PER_STAGE = 4;
    localparam int unsigned DIV_STAGES      = DIVIDEND_W / STEPS_PER_STAGE;
    // entry, correction, product, divider stages, output
    localparam int unsigned NUM_STAGES      = DIV_STAGES + 4;
    localparam int unsigned IN_W            = 4 * CH_W;

    localparam logic [SET_W-1:0]  SETTING_RESET     = 8'd235;
    localparam logic [SET_W:0]    CYCLE_BASE        = 9'd256;
    localparam logic [SET_W:0]    ANALOG_MAX_CYCLES = 9'd63;
    localparam logic [CH_W-1:0]   SAT_DIGITAL       = 16'hFFFF;
    localparam logic [9:0]        SAT_PER_CYCLE     = 10'd768;  // 1024 counts less a quarter
    localparam logic [COEF_W-1:0] CCT_COEF          = 12'd3810;
    localparam logic [CH_W-1:0]   CCT_OFFSET        = 16'd1391;

    typedef struct packed {
        logic [DIVIDEND_W-1:0] x;    // dividend shifts out the top, quotient in the bottom
        logic [CH_W-1:0]       rem;
        logic [CH_W-1:0]       den;
    } t_div;

    // One restoring division step.
    function automatic t_div div_step(input t_div d);
        t_div          o;
        logic [CH_W:0] t;
        logic          ge;
        t  = {d.rem, d.x[DIVIDEND_W-1]};
        ge = (t >= {1'b0, d.den});
        o.den = d.den;
        o.rem = ge ? CH_W'(t - {1'b0, d.den}) : t[CH_W-1:0];
        o.x   = {d.x[DIVIDEND_W-2:0], ge};
        return o;
    endfunction

endpackage

// ===== design/ratio_color_temperature_top.sv =====
// Top level: pipelined ratio color temperature from raw R, G, B and clear counts.
//
// Usage
//   Input stream (s_axis): one transfer carries one sample; tdata packs, from the
//   lowest bit up, red_count, green_count, blue_count, clear_count (16 bits each).
//   Output stream (m_axis): one transfer per sample, in order; tdata holds
//   temperature_kelvin (16 bits), zero for a dark, saturated or degenerate sample.
//   Configuration: drive i_cfg_wr_en for one cycle with the integration setting on
//   i_cfg_wr_data; change it only while no sample is in flight.
// Pipeline and throughput
//   Eleven register stages: entry, IR correction, coefficient multiply, seven divider
//   stages of four restoring steps each (28-bit quotient), and the output adder.
//   One sample enters every cycle while the pipe is not full behind a stalled
//   receiver.
// Reset
//   i_rst_n low clears all stage valid bits and loads the setting 235.
// Stall
//   Each stage holds while it is full and the next one holds; empty stages keep
//   filling, so bubbles collapse and the input stays ready until the whole pipe
//   is full behind a stalled receiver. Nothing is dropped or repeated.
module ratio_color_temperature_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [rct_pkg::SET_W-1:0]   i_cfg_wr_data,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // red_count, green_count, blue_count, clear_count from the lowest bit up
    input  logic [rct_pkg::IN_W-1:0]    i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // temperature_kelvin
    output logic [rct_pkg::CH_W-1:0]    o_m_axis_tdata
);
    import rct_pkg::*;

    localparam int unsigned S_ENTRY = 0;
    localparam int unsigned S_CORR  = 1;
    localparam int unsigned S_PROD  = 2;
    localparam int unsigned S_DIV0  = 3;
    localparam int unsigned S_OUT   = NUM_STAGES - 1;

    // configuration register
    logic [SET_W-1:0] r_setting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setting <= SETTING_RESET;
        end else if (i_cfg_wr_en) begin
            r_setting <= i_cfg_wr_data;
        end
    end

    // saturation limit: 65535 when 256 minus the setting exceeds 63, else 768 counts per unit of that difference
    logic [SET_W:0]  cycles;
    logic [CH_W-1:0] sat_limit;

    always_comb begin
        cycles = CYCLE_BASE - {1'b0, r_setting};
        if (cycles > ANALOG_MAX_CYCLES) begin
            sat_limit = SAT_DIGITAL;
        end else begin
            sat_limit = CH_W'(cycles[5:0]) * CH_W'(SAT_PER_CYCLE);
        end
    end

    // stage valid bits and per-stage advance; a stage loads when empty or draining
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stg_en;

    always_comb begin
        stg_en[S_OUT] = !r_vld[S_OUT] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign o_s_axis_tready = stg_en[S_ENTRY];
    assign o_m_axis_tvalid = r_vld[S_OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_en[S_ENTRY]) begin
                r_vld[S_ENTRY] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // entry stage: channel sum and dark / saturation check
    logic [CH_W-1:0] in_red, in_green, in_blue, in_clear;

    assign in_red   = i_s_axis_tdata[CH_W-1:0];
    assign in_green = i_s_axis_tdata[2*CH_W-1:CH_W];
    assign in_blue  = i_s_axis_tdata[3*CH_W-1:2*CH_W];
    assign in_clear = i_s_axis_tdata[4*CH_W-1:3*CH_W];

    logic [CH_W-1:0]  r_e_red, r_e_blue, r_e_clear;
    logic [SUM_W-1:0] r_e_sum;
    logic             r_e_bad;

    always_ff @(posedge i_clk) begin
        if (stg_en[S_ENTRY]) begin
            r_e_red   <= in_red;
            r_e_blue  <= in_blue;
            r_e_clear <= in_clear;
            r_e_sum   <= SUM_W'(in_red) + SUM_W'(in_green) + SUM_W'(in_blue);
            r_e_bad   <= (in_clear == '0) || (in_clear >= sat_limit);
        end
    end

    // correction stage: remove half the excess of R+G+B over clear, wrapping at 16 bits
    logic [SUM_W-1:0] excess;
    logic [CH_W-1:0]  ir, red2, blue2;

    always_comb begin
        excess = r_e_sum - SUM_W'(r_e_clear);
        ir     = (r_e_sum > SUM_W'(r_e_clear)) ? excess[CH_W:1] : '0;
        red2   = r_e_red - ir;
        blue2  = r_e_blue - ir;
    end

    logic [CH_W-1:0] r_c_red2, r_c_blue2;
    logic            r_c_bad;

    always_ff @(posedge i_clk) begin
        if (stg_en[S_CORR]) begin
            r_c_red2  <= red2;
            r_c_blue2 <= blue2;
            r_c_bad   <= r_e_bad || (red2 == '0);
        end
    end

    // product stage: scaled blue becomes the dividend
    logic [DIVIDEND_W-1:0] r_p_prod;
    logic [CH_W-1:0]       r_p_den;
    logic                  r_p_bad;

    always_ff @(posedge i_clk) begin
        if (stg_en[S_PROD]) begin
            r_p_prod <= DIVIDEND_W'(r_c_blue2) * DIVIDEND_W'(CCT_COEF);
            r_p_den  <= r_c_red2;
            r_p_bad  <= r_c_bad;
        end
    end

    // divider stages: STEPS_PER_STAGE restoring steps each
    t_div r_div     [DIV_STAGES];
    logic r_div_bad [DIV_STAGES];
    t_div n_div     [DIV_STAGES];
    logic n_div_bad [DIV_STAGES];

    always_comb begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (j == 0) begin
                n_div[j].x   = r_p_prod;
                n_div[j].rem = '0;
                n_div[j].den = r_p_den;
                n_div_bad[j] = r_p_bad;
            end else begin
                n_div[j]     = r_div[j-1];
                n_div_bad[j] = r_div_bad[j-1];
            end
            for (int s = 0; s < STEPS_PER_STAGE; s++) begin
                n_div[j] = div_step(n_div[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (stg_en[S_DIV0 + j]) begin
                r_div[j]     <= n_div[j];
                r_div_bad[j] <= n_div_bad[j];
            end
        end
    end

    // output stage: add the offset, force zero for rejected samples
    logic [CH_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (stg_en[S_OUT]) begin
            r_out <= r_div_bad[DIV_STAGES-1] ? '0
                   : r_div[DIV_STAGES-1].x[CH_W-1:0] + CCT_OFFSET;
        end
    end

    assign o_m_axis_tdata = r_out;

endmodule
